@@ hw/rtl/sll_pkg.sv @@
// Shared types and constants for the static linked list engine.
// No dependencies; every other file except sll_ram imports this package.
package sll_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 8;
    localparam int COUNT_W   = 6;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2,
        OP_LENGTH   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        t_op              operation;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   element;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               empty_res;
    } t_res_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_ALLOC,
        S_SPLICE,
        S_UNLINK,
        S_RELEASE,
        S_TRAVERSE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    latch;
        logic    walk_init;
        logic    walk_step;
        logic    rd_free;
        logic    alloc;
        logic    splice;
        logic    unlink;
        logic    release_slot;
        logic    emit;
        t_status emit_status;
        logic    emit_elem;
        logic    emit_last;
        logic    emit_empty;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic pos_bad;
        logic full;
        logic list_empty;
        logic steps_done;
        logic link_end;
    } t_dp_stat;

endpackage

@@ hw/rtl/sll_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sll_ctrl.sv @@
// Sequencer for the linked list engine: decodes operations and steps the datapath.
// Depends on sll_pkg.
module sll_ctrl
    import sll_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.emit_status = ST_OK;
        o_busy            = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_BADPOS;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else if (i_stat.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_FULL;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                    OP_DELETE: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_BADPOS;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                    OP_TRAVERSE: begin
                        if (i_stat.list_empty) begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.emit_last  = 1'b1;
                            o_cmd.emit_empty = 1'b1;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_TRAVERSE;
                        end
                    end
                    default: begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                if (!i_stat.steps_done) begin
                    o_cmd.walk_step = 1'b1;
                end else if (i_stat.op == OP_INSERT) begin
                    // fetch the link of the free stack top for the pop
                    o_cmd.rd_free = 1'b1;
                    n_state       = S_ALLOC;
                end else begin
                    n_state = S_UNLINK;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_SPLICE;
            end
            S_SPLICE: begin
                o_cmd.splice    = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_RELEASE;
            end
            S_RELEASE: begin
                o_cmd.release_slot = 1'b1;
                o_cmd.emit         = 1'b1;
                o_cmd.emit_last    = 1'b1;
                n_state            = S_IDLE;
            end
            S_TRAVERSE: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_elem = 1'b1;
                o_cmd.emit_last = i_stat.link_end;
                if (i_stat.link_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/sll_dp.sv @@
// Datapath of the linked list engine: pointers, counters, link and value memories,
// result register. Depends on sll_pkg and sll_ram.
module sll_dp
    import sll_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_res_strobe,
    output t_res_item o_res
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam logic [AW-1:0] CAPACITY = AW'(SLOTS - 2);

    t_op              r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [POS_W-1:0] r_steps;
    logic [AW-1:0]    r_head;   // first list slot, 0 when empty
    logic [AW-1:0]    r_free;   // top of recycled-slot stack, 0 when empty
    logic [AW-1:0]    r_fresh;  // next never-used slot
    logic [AW-1:0]    r_count;
    logic [AW-1:0]    r_prev;
    logic             r_prev_head;
    logic [AW-1:0]    r_cur;
    logic [AW-1:0]    r_slot;
    logic             r_res_strobe;
    t_res_item        r_res;

    logic [AW-1:0]    n_count;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    link_rdata;
    logic [VAL_W-1:0] val_rdata;
    logic             link_we;
    logic [AW-1:0]    link_waddr;
    logic [AW-1:0]    link_wdata;
    logic [AW-1:0]    alloc_slot;
    logic             stack_empty;
    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    cnt_ext;
    logic [PW-1:0]    out_cnt_ext;

    assign stack_empty = (r_free == '0);
    assign alloc_slot  = stack_empty ? r_fresh : r_free;
    assign pos_ext     = PW'(r_pos);
    assign cnt_ext     = PW'(r_count);

    always_comb begin
        n_count = r_count;
        if (i_cmd.splice) begin
            n_count = r_count + AW'(1);
        end else if (i_cmd.release_slot) begin
            n_count = r_count - AW'(1);
        end
    end

    assign out_cnt_ext = PW'(n_count);

    // read address follows the cursor, so each walk step reads the next link as the cursor advances
    always_comb begin
        if (i_cmd.walk_init) begin
            rd_addr = r_head;
        end else if (i_cmd.walk_step) begin
            rd_addr = link_rdata;
        end else if (i_cmd.rd_free) begin
            rd_addr = r_free;
        end else begin
            rd_addr = r_cur;
        end
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = r_free;
        if (i_cmd.alloc) begin
            link_we    = 1'b1;
            link_waddr = alloc_slot;
            link_wdata = r_cur;
        end else if (i_cmd.splice) begin
            link_we    = !r_prev_head;
            link_waddr = r_prev;
            link_wdata = r_slot;
        end else if (i_cmd.unlink) begin
            link_we    = !r_prev_head;
            link_waddr = r_prev;
            link_wdata = link_rdata;
        end else if (i_cmd.release_slot) begin
            link_we    = 1'b1;
            link_waddr = r_cur;
            link_wdata = r_free;
        end
    end

    sll_ram #(
        .WIDTH(AW),
        .DEPTH(SLOTS)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(rd_addr),
        .o_rdata(link_rdata)
    );

    sll_ram #(
        .WIDTH(VAL_W),
        .DEPTH(SLOTS)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.alloc),
        .i_waddr(alloc_slot),
        .i_wdata(r_val),
        .i_raddr(rd_addr),
        .o_rdata(val_rdata)
    );

    // payload, walk, slot and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_item.operation;
            r_pos <= i_item.position;
            r_val <= i_item.value;
        end
        if (i_cmd.walk_init) begin
            r_prev_head <= 1'b1;
            r_cur       <= r_head;
            r_steps     <= r_pos - POS_W'(1);
        end else if (i_cmd.walk_step) begin
            r_prev_head <= 1'b0;
            r_prev      <= r_cur;
            r_cur       <= link_rdata;
            r_steps     <= r_steps - POS_W'(1);
        end
        if (i_cmd.alloc) begin
            r_slot <= alloc_slot;
        end
        r_res.status    <= i_cmd.emit_status;
        r_res.element   <= i_cmd.emit_elem ? val_rdata : '0;
        r_res.count     <= out_cnt_ext[COUNT_W-1:0];
        r_res.last      <= i_cmd.emit_last;
        r_res.empty_res <= i_cmd.emit_empty;
    end

    // list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_free       <= '0;
            r_fresh      <= AW'(1);
            r_count      <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_res_strobe <= i_cmd.emit;
            if (i_cmd.alloc) begin
                if (stack_empty) begin
                    r_fresh <= r_fresh + AW'(1);
                end else begin
                    r_free <= link_rdata;
                end
            end
            if (i_cmd.splice && r_prev_head) begin
                r_head <= r_slot;
            end
            if (i_cmd.unlink && r_prev_head) begin
                r_head <= link_rdata;
            end
            if (i_cmd.release_slot) begin
                r_free <= r_cur;
            end
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.pos_bad    = (r_pos == '0) ||
                            ((r_op == OP_INSERT) ? (pos_ext > cnt_ext + PW'(1))
                                                 : (pos_ext > cnt_ext));
        o_stat.full       = (r_count == CAPACITY);
        o_stat.list_empty = (r_head == '0);
        o_stat.steps_done = (r_steps == '0);
        o_stat.link_end   = (link_rdata == '0);
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

endmodule

@@ hw/rtl/static_linked_list_engine.sv @@
// Top level of the static linked list engine: controller plus datapath.
// Depends on sll_pkg, sll_ctrl, sll_dp (and sll_ram below it).
//
//   channel   direction   handshake                  payload
//   command   in          start high, busy low       i_item  (t_in_item)
//   result    out         o_res_strobe, one cycle    o_res   (t_res_item)
//
// Length query and rejected operations give their result straight from decode. Insert
// and delete at position p walk p - 1 steps, one link memory read per walk step, then
// allocate and splice, or unlink and release. Traverse: one element per cycle.
// Busy drops in the cycle that carries the final result, so the next command can
// transfer at the edge that takes it. Synchronous reset, no clearing pass: a command
// is taken the cycle after reset. The receiver cannot stall.
module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_res_strobe,
    output t_res_item o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sll_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    sll_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

endmodule

@@ hw/rtl/sll_checker.sv @@
// Port-level checks for static_linked_list_engine, attached with a bind.
// Depends on sll_pkg.
module sll_checker
    import sll_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_res_strobe,
    input t_res_item o_res
);

    // an accepted command keeps the engine busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after command transfer");

    // the final result frees the engine, earlier ones keep it busy
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last) |-> !busy)
        else $error("engine busy with final result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.last) |-> busy)
        else $error("engine idle during a traverse");

    // an error or an empty traverse is a single result with no element
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.status != ST_OK || o_res.empty_res)) |->
        (o_res.last && o_res.element == '0))
        else $error("error or empty result not a lone transfer");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.empty_res) |-> (o_res.count == '0))
        else $error("empty traverse with non-zero count");

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_strobe(o_res_strobe),
    .o_res       (o_res)
);

@@ dv/static_linked_list_engine_test.sv @@
// Self-checking testbench for the static linked list engine: a scoreboard class
// mirrors the slot array and checks every strobed result. Depends on sll_pkg and static_linked_list_engine.
`timescale 1ns / 100ps
module static_linked_list_engine_test
    import sll_pkg::*;
();

    localparam int HEAD_SLOT    = SLOTS_DEF - 1;
    localparam int CAPACITY     = SLOTS_DEF - 2;
    localparam int LIMIT_CYCLES = 250000;
    localparam int SETTLE       = 12;
    localparam int MODE_GROW    = 0;
    localparam int MODE_SHRINK  = 1;
    localparam int MODE_MIXED   = 2;

    class list_scoreboard;
        logic [POS_W-1:0] link_of [SLOTS_DEF];
        logic [VAL_W-1:0] byte_at [SLOTS_DEF];
        int               fill;
        t_res_item        awaited[$];
        int               errors;
        int               checked;
        int               full_hits;
        int               bad_hits;
        int               peak;

        function new();
            for (int i = 0; i < SLOTS_DEF; i++) begin
                link_of[i] = POS_W'(i + 1);
            end
            link_of[SLOTS_DEF-2] = '0;
            link_of[HEAD_SLOT]   = '0;
            fill      = 0;
            errors    = 0;
            checked   = 0;
            full_hits = 0;
            bad_hits  = 0;
            peak      = 0;
        endfunction

        // Slot that precedes list position pos
        function int slot_before(int pos);
            int prev;
            prev = HEAD_SLOT;
            for (int i = 1; i < pos; i++) begin
                prev = link_of[prev];
            end
            return prev;
        endfunction

        function void accept_command(t_in_item cmd);
            t_res_item r;
            int        pos;
            int        prev;
            int        slot;
            r      = '0;
            r.last = 1'b1;
            pos    = cmd.position;
            case (cmd.operation)
                OP_INSERT: begin
                    if (pos < 1 || pos > fill + 1) begin
                        r.status = ST_BADPOS;
                        bad_hits++;
                    end else if (link_of[0] == '0) begin
                        r.status = ST_FULL;
                        full_hits++;
                    end else begin
                        slot          = link_of[0];
                        link_of[0]    = link_of[slot];
                        byte_at[slot] = cmd.value;
                        prev          = slot_before(pos);
                        link_of[slot] = link_of[prev];
                        link_of[prev] = POS_W'(slot);
                        fill++;
                        if (fill > peak) peak = fill;
                    end
                    r.count = COUNT_W'(fill);
                    awaited.push_back(r);
                end
                OP_DELETE: begin
                    if (pos < 1 || pos > fill) begin
                        r.status = ST_BADPOS;
                        bad_hits++;
                    end else begin
                        // unlink, then push the slot onto the front of the free chain
                        prev          = slot_before(pos);
                        slot          = link_of[prev];
                        link_of[prev] = link_of[slot];
                        link_of[slot] = link_of[0];
                        link_of[0]    = POS_W'(slot);
                        fill--;
                    end
                    r.count = COUNT_W'(fill);
                    awaited.push_back(r);
                end
                OP_TRAVERSE: begin
                    r.count = COUNT_W'(fill);
                    slot    = link_of[HEAD_SLOT];
                    if (slot == 0) begin
                        r.empty_res = 1'b1;
                        awaited.push_back(r);
                    end
                    while (slot != 0) begin
                        r.element = byte_at[slot];
                        slot      = link_of[slot];
                        r.last    = (slot == 0);
                        awaited.push_back(r);
                    end
                end
                default: begin
                    r.count = COUNT_W'(fill);
                    awaited.push_back(r);
                end
            endcase
        endfunction

        function void check_result(t_res_item got);
            t_res_item want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %s",
                         $time, $sformatf("status=%0d elem=%h cnt=%0d last=%b empty=%b",
                         got.status, got.element, got.count, got.last, got.empty_res));
            end else begin
                want = awaited.pop_front();
                checked++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch, expected status=%0d elem=%h cnt=%0d %s",
                             $time, want.status, want.element, want.count,
                             $sformatf("last=%b empty=%b", want.last, want.empty_res));
                    $display("%0t:           actual status=%0d elem=%h cnt=%0d %s",
                             $time, got.status, got.element, got.count,
                             $sformatf("last=%b empty=%b", got.last, got.empty_res));
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_res_strobe;
    t_res_item o_res;

    list_scoreboard sb;
    int             cycles;
    int             sent;
    int             burst_left;
    bit             gaps_on;

    static_linked_list_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.accept_command(i_item);
            if (o_res_strobe) sb.check_result(o_res);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.awaited.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one command and hold it until the transfer; then maybe idle
    task automatic send_cmd(input t_op op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        t_in_item cmd;
        cmd.operation = op;
        cmd.position  = pos;
        cmd.value     = val;
        start  <= 1'b1;
        i_item <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(0, 9);
            end
        end
    endtask

    // Hold off until every outstanding result has arrived
    task automatic drain();
        start <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] pick_pos(int span);
        case ($urandom_range(0, 3))
            0:       return POS_W'(1);
            1:       return POS_W'(span);
            default: return POS_W'($urandom_range(1, span));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_bad_pos(int span);
        if (span + 1 > 63 || $urandom_range(0, 2) == 0) return '0;
        return POS_W'($urandom_range(span + 1, 63));
    endfunction

    task automatic random_cmd(input int mode);
        int n;
        int roll;
        int ins_pct;
        int del_pct;
        n    = sb.fill;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:   begin ins_pct = 85; del_pct = 4;  end
            MODE_SHRINK: begin ins_pct = 10; del_pct = 78; end
            default:     begin ins_pct = 42; del_pct = 36; end
        endcase
        if (roll < 5) begin
            send_cmd(t_op'($urandom_range(0, 3)), POS_W'($urandom_range(0, 63)),
                     VAL_W'($urandom_range(0, 255)));
        end else if (roll < 5 + ins_pct) begin
            send_cmd(OP_INSERT, ($urandom_range(0, 11) == 0) ? pick_bad_pos(n + 1)
                                                             : pick_pos(n + 1),
                     VAL_W'($urandom_range(0, 255)));
        end else if (roll < 5 + ins_pct + del_pct) begin
            send_cmd(OP_DELETE, (n == 0 || $urandom_range(0, 11) == 0) ? pick_bad_pos(n)
                                                                       : pick_pos(n),
                     VAL_W'($urandom_range(0, 255)));
        end else begin
            send_cmd(($urandom_range(0, 1) == 0) ? OP_TRAVERSE : OP_LENGTH,
                     POS_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(input int mode, input int items, input bit with_gaps);
        gaps_on    = with_gaps;
        burst_left = $urandom_range(0, 9);
        repeat (items) random_cmd(mode);
        drain();
    endtask

    initial begin
        sb         = new();
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        cycles     = 0;
        sent       = 0;
        burst_left = 0;
        gaps_on    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty list, rejected positions, inserts at front, middle and end, then unlink
        send_cmd(OP_LENGTH,   6'd0,  8'h00);
        send_cmd(OP_TRAVERSE, 6'd63, 8'hFF);
        send_cmd(OP_DELETE,   6'd1,  8'h00);
        send_cmd(OP_INSERT,   6'd0,  8'h11);
        send_cmd(OP_INSERT,   6'd2,  8'h22);
        send_cmd(OP_INSERT,   6'd1,  8'h00);
        send_cmd(OP_INSERT,   6'd2,  8'hFF);
        send_cmd(OP_INSERT,   6'd1,  8'hA5);
        send_cmd(OP_INSERT,   6'd3,  8'h5A);
        send_cmd(OP_TRAVERSE, 6'd0,  8'h00);
        send_cmd(OP_DELETE,   6'd0,  8'h00);
        send_cmd(OP_DELETE,   6'd5,  8'h00);
        send_cmd(OP_DELETE,   6'd63, 8'hFF);
        send_cmd(OP_DELETE,   6'd2,  8'h00);
        send_cmd(OP_DELETE,   6'd3,  8'h00);
        send_cmd(OP_INSERT,   6'd63, 8'h77);
        send_cmd(OP_TRAVERSE, 6'd21, 8'h3C);
        send_cmd(OP_LENGTH,   6'd63, 8'hFF);
        send_cmd(OP_DELETE,   6'd1,  8'hFF);
        send_cmd(OP_DELETE,   6'd1,  8'h00);
        send_cmd(OP_TRAVERSE, 6'd0,  8'h00);
        drain();

        run_phase(MODE_GROW,   100, 1'b1);
        run_phase(MODE_MIXED,   60, 1'b0);
        run_phase(MODE_SHRINK,  70, 1'b1);
        run_phase(MODE_GROW,    55, 1'b1);
        run_phase(MODE_MIXED,   55, 1'b1);

        if (sb.awaited.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.awaited.size());
        $display("Ran %0d commands and checked %0d results; longest list %0d of %0d.",
                 sent, sb.checked, sb.peak, CAPACITY);
        $display("Rejections seen: %0d store full, %0d bad position.",
                 sb.full_hits, sb.bad_hits);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sll_pkg.sv
hw/rtl/sll_ram.sv
hw/rtl/sll_ctrl.sv
hw/rtl/sll_dp.sv
hw/rtl/static_linked_list_engine.sv
hw/rtl/sll_checker.sv
dv/static_linked_list_engine_test.sv
